[sv/i2cmbe_pkg.sv]
// Shared types, codes and reset values for the I2C master bit engine.
`default_nettype none

package i2cmbe_pkg;

    // Command codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_READ     = 3'd3,
        MODE_WAIT_ACK = 3'd4
    } t_mode;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_HOLD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS  = 2'd2;
    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [7:0] ACK_POLL_LIMIT_RST  = 8'd250;
    localparam logic [3:0] EDGE_HOLD_TICKS_RST = 4'd4;
    localparam logic [3:0] HALF_BIT_TICKS_RST  = 4'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_res;

endpackage

`default_nettype wire

[sv/i2cmbe_if.sv]
// Handshake interfaces for the command, result and configuration channels.
`default_nettype none

interface i2cmbe_cmd_if;
    logic                valid;
    logic                ready;
    i2cmbe_pkg::t_cmd    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cmbe_res_if;
    logic                valid;
    logic                ready;
    i2cmbe_pkg::t_res    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cmbe_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [i2cmbe_pkg::CFG_IDX_W-1:0]     index;
    logic [i2cmbe_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/i2c_master_bit_engine.sv]
// I2C master bit engine: pin sequencer for start, stop, byte write, byte read and ack wait.
// Each accepted request on i_cmd is one bus tick and yields exactly one result on o_res
// showing the SCL/SDA pin registers and status after that tick. The tick logic is a single
// registered step, so the result of a request is valid on o_res the cycle after it is
// accepted. A request is taken every cycle as long as the result register is empty or
// being drained in the same cycle; o_res stalls hold back i_cmd. A command is
// taken only while the sequencer is idle (busy_res low); commands seen while busy are
// dropped. Start/stop edges last edge_hold_ticks ticks; write data, read low and ack half
// bits last half_bit_ticks ticks (not the read high half bit); a hold of zero acts as one tick.
// Configuration writes on i_cfg are always taken and should be issued only while idle; an
// index past the last register is ignored.
`default_nettype none

module i2c_master_bit_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    i2cmbe_cmd_if.sink       i_cmd,
    i2cmbe_res_if.source     o_res,
    i2cmbe_cfg_if.sink       i_cfg
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WR_LO, PH_WR_HI,
        PH_RD_LO, PH_RD_HI, PH_RD_HOLD, PH_AK_LO, PH_AK_HI,
        PH_WA_REL, PH_WA_RISE, PH_WA_POLL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_index, n_bit_index;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_tick, n_tick;
    logic [8:0]  r_poll, n_poll;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drv, n_drv;
    logic        r_ack_err, n_ack_err;
    logic        r_pend_ack, n_pend_ack;
    logic [7:0]  r_rx, n_rx;
    logic        r_done, n_done;
    logic        r_res_valid;

    logic [7:0]  r_poll_limit;
    logic [3:0]  r_edge_hold;
    logic [3:0]  r_half_bit;

    logic        w_in_acc;
    logic [3:0]  w_hold;
    logic [8:0]  w_poll_inc;
    logic [3:0]  w_bit_inc;

    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid           = r_res_valid;
    assign o_res.data.scl_level  = r_scl;
    assign o_res.data.sda_level  = r_sda;
    assign o_res.data.sda_drive  = r_drv;
    assign o_res.data.busy_res   = (r_phase != PH_IDLE);
    assign o_res.data.done_res   = r_done;
    assign o_res.data.rx_byte    = r_rx;
    assign o_res.data.ack_error  = r_ack_err;

    assign w_poll_inc = r_poll + 9'd1;
    assign w_bit_inc  = r_bit_index + 4'd1;

    // Segment length of the current phase
    always_comb begin
        unique case (r_phase) inside
            PH_ST1, PH_ST2, PH_SP1, PH_SP2: w_hold = r_edge_hold;
            PH_WR_LO, PH_WR_HI, PH_RD_LO, PH_AK_LO, PH_AK_HI: w_hold = r_half_bit;
            default: w_hold = 4'd1;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_poll      = r_poll;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_drv       = r_drv;
        n_ack_err   = r_ack_err;
        n_pend_ack  = r_pend_ack;
        n_rx        = r_rx;
        n_done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_cmd.data.cmd_valid) begin
                unique case (i_cmd.data.mode)
                    i2cmbe_pkg::MODE_START: begin
                        n_phase = PH_ST1; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                        n_tick = 4'd1;
                    end
                    i2cmbe_pkg::MODE_STOP: begin
                        n_phase = PH_SP1; n_scl = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
                        n_tick = 4'd1;
                    end
                    i2cmbe_pkg::MODE_WRITE: begin
                        n_bit_index = 4'd0;
                        n_shift = {i_cmd.data.tx_byte[6:0], 1'b0};
                        n_phase = PH_WR_LO; n_scl = 1'b0; n_sda = i_cmd.data.tx_byte[7];
                        n_drv = 1'b1; n_tick = 4'd1;
                    end
                    i2cmbe_pkg::MODE_READ: begin
                        n_shift = 8'd0; n_bit_index = 4'd0;
                        n_pend_ack = i_cmd.data.send_ack;
                        n_phase = PH_RD_LO; n_scl = 1'b0; n_drv = 1'b0; n_tick = 4'd1;
                    end
                    i2cmbe_pkg::MODE_WAIT_ACK: begin
                        n_phase = PH_WA_REL; n_sda = 1'b1; n_drv = 1'b0; n_tick = 4'd1;
                    end
                    default: ;
                endcase
            end
        end else if (r_phase == PH_WA_POLL) begin
            if (!i_cmd.data.sda_sample) begin
                n_scl = 1'b0; n_ack_err = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
            end else begin
                n_poll = w_poll_inc;
                // timed out: flag and release the bus with a stop
                if (w_poll_inc > {1'b0, r_poll_limit}) begin
                    n_ack_err = 1'b1;
                    n_phase = PH_SP1; n_scl = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
                    n_tick = 4'd1;
                end
            end
        end else if (r_tick < w_hold) begin
            n_tick = r_tick + 4'd1;
        end else begin
            n_tick = 4'd1;
            unique case (r_phase)
                PH_ST1: begin
                    n_phase = PH_ST2; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                end
                PH_ST2: begin
                    n_tick = r_tick; n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                end
                PH_SP1: begin
                    n_phase = PH_SP2; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                end
                PH_SP2: begin
                    n_tick = r_tick; n_sda = 1'b1; n_phase = PH_IDLE; n_done = 1'b1;
                end
                PH_WR_LO: begin
                    n_phase = PH_WR_HI; n_scl = 1'b1; n_drv = 1'b1;
                end
                PH_WR_HI: begin
                    n_bit_index = w_bit_inc;
                    if (w_bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_WR_LO; n_scl = 1'b0; n_sda = r_shift[7]; n_drv = 1'b1;
                    end else begin
                        n_tick = r_tick; n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                    end
                end
                PH_RD_LO: begin
                    n_phase = PH_RD_HI; n_scl = 1'b1; n_drv = 1'b0;
                end
                PH_RD_HI: begin
                    n_shift = {r_shift[6:0], i_cmd.data.sda_sample};
                    n_phase = PH_RD_HOLD; n_scl = 1'b1; n_drv = 1'b0;
                end
                PH_RD_HOLD: begin
                    n_bit_index = w_bit_inc;
                    if (w_bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
                        n_phase = PH_RD_LO; n_scl = 1'b0; n_drv = 1'b0;
                    end else begin
                        n_rx = r_shift;
                        n_phase = PH_AK_LO; n_scl = 1'b0; n_sda = !r_pend_ack; n_drv = 1'b1;
                    end
                end
                PH_AK_LO: begin
                    n_phase = PH_AK_HI; n_scl = 1'b1; n_drv = 1'b1;
                end
                PH_AK_HI: begin
                    n_tick = r_tick; n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                end
                PH_WA_REL: begin
                    n_phase = PH_WA_RISE; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b0;
                end
                PH_WA_RISE: begin
                    n_poll = 9'd0;
                    n_phase = PH_WA_POLL; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b0;
                end
                default: begin
                    n_tick = r_tick; n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= 4'd0;
            r_shift      <= 8'd0;
            r_tick       <= 4'd0;
            r_poll       <= 9'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
            r_ack_err    <= 1'b0;
            r_pend_ack   <= 1'b0;
            r_rx         <= 8'd0;
            r_done       <= 1'b0;
            r_res_valid  <= 1'b0;
            r_poll_limit <= i2cmbe_pkg::ACK_POLL_LIMIT_RST;
            r_edge_hold  <= i2cmbe_pkg::EDGE_HOLD_TICKS_RST;
            r_half_bit   <= i2cmbe_pkg::HALF_BIT_TICKS_RST;
        end else begin
            if (w_in_acc) begin
                r_phase     <= n_phase;
                r_bit_index <= n_bit_index;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_poll      <= n_poll;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_drv       <= n_drv;
                r_ack_err   <= n_ack_err;
                r_pend_ack  <= n_pend_ack;
                r_rx        <= n_rx;
                r_done      <= n_done;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    i2cmbe_pkg::CFG_ACK_POLL_LIMIT:  r_poll_limit <= i_cfg.data;
                    i2cmbe_pkg::CFG_EDGE_HOLD_TICKS: r_edge_hold  <= i_cfg.data[3:0];
                    i2cmbe_pkg::CFG_HALF_BIT_TICKS:  r_half_bit   <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_done_means_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_phase == PH_IDLE)
        else $error("done pulse while sequencer busy");

    a_poll_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WA_POLL |-> !r_drv && r_scl)
        else $error("SDA driven or SCL low while polling for ack");

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_phase == PH_IDLE && !i_cmd.data.cmd_valid
        |=> r_phase == PH_IDLE && !r_done && r_res_valid)
        else $error("idle tick without command changed state");

    a_start_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ST2 |-> r_scl && !r_sda && r_drv)
        else $error("start condition pins wrong");
`endif

endmodule

`default_nettype wire
